// ===== rtl/wtc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtc_pkg
// Shared widths, constants and the data record passed along the cell chain.
// ----------------------------------------------------------------------------
package wtc_pkg;

    localparam int FREQ_W   = 32;
    localparam int COUNT_W  = 13;
    localparam int CLK_W    = 30;
    localparam int TW_W     = 24;
    localparam int TWREM_W  = CLK_W + 1;
    localparam int DEN_W    = FREQ_W + COUNT_W;
    localparam int HREM_W   = DEN_W + 1;
    localparam int HQ_W     = 9;
    localparam int CMP_W    = DEN_W + HQ_W;
    localparam int HOLD_W   = 8;
    localparam int PERIOD_W = 16;
    localparam int STOP_W   = 12;
    localparam int N_CELLS  = TW_W;

    localparam logic [CLK_W-1:0]    CLOCK_RESET  = 30'd100000000;
    localparam logic [HOLD_W-1:0]   HOLD_MAX     = 8'd255;
    localparam logic [PERIOD_W-1:0] PERIOD_MAX   = 16'hFFFF;
    localparam logic [7:0]          TIMEBASE_LOW = 8'h11;

    localparam int HMODE_PASS = 0;
    localparam int HMODE_INIT = 1;
    localparam int HMODE_STEP = 2;

    typedef struct packed {
        logic               valid;
        logic [TWREM_W-1:0] tw_rem;
        logic [TW_W-1:0]    tw_q;
        logic [HREM_W-1:0]  h_rem;
        logic [DEN_W-1:0]   h_den;
        logic [HQ_W-1:0]    h_q;
        logic [COUNT_W-1:0] count;
        logic               err;
    } cell_data_t;

endpackage

// ===== rtl/waveform_timing_calculator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waveform_timing_calculator
// DDS tuning word and pattern playback timing from frequency and sample count.
// ----------------------------------------------------------------------------
// Fully pipelined: one transaction accepted per cycle, passing through an input
// register, 24 division cells and an output register. The 24-cell chain gives
// one tuning word quotient bit per cell; the hold quotient is produced in cells
// 1 to 9 of the same chain. The whole pipeline stalls together when the result
// is not taken.
module waveform_timing_calculator import wtc_pkg::*; #(
    parameter int MAX_SAMPLES = 4096
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [CLK_W-1:0]    cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [FREQ_W-1:0]   s_frequency_hz,
    input  logic [COUNT_W-1:0]  s_sample_count,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [TW_W-1:0]     m_tuning_word,
    output logic [HOLD_W-1:0]   m_sample_hold,
    output logic [PERIOD_W-1:0] m_pattern_period,
    output logic [STOP_W-1:0]   m_stop_address,
    output logic [PERIOD_W-1:0] m_timebase_word,
    output logic                m_count_error
);

    localparam logic [COUNT_W-1:0] CNT_MAX = COUNT_W'(MAX_SAMPLES);

    logic [CLK_W-1:0]    dac_clock_reg;
    logic [CLK_W-1:0]    clk_eff;
    logic                adv;
    logic [FREQ_W-1:0]   fc;
    logic [COUNT_W-1:0]  count_sat;
    cell_data_t          s0_reg;
    cell_data_t          s0_next;
    cell_data_t          chain [N_CELLS+1];

    logic                m_valid_reg;
    logic [TW_W-1:0]     tw_reg;
    logic [HOLD_W-1:0]   hold_reg;
    logic [PERIOD_W-1:0] period_reg;
    logic [STOP_W-1:0]   stop_reg;
    logic [PERIOD_W-1:0] tb_reg;
    logic                err_reg;
    logic [HOLD_W-1:0]   hold_next;
    logic [PERIOD_W-1:0] period_next;
    logic [COUNT_W+HOLD_W-1:0] prod;
    cell_data_t          last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dac_clock_reg <= CLOCK_RESET;
        end else if (cfg_wr_en) begin
            dac_clock_reg <= cfg_wr_data;
        end
    end

    assign clk_eff = (dac_clock_reg < CLK_W'(2)) ? CLK_W'(2) : dac_clock_reg;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    always_comb begin
        fc = s_frequency_hz;
        if (fc == '0) begin
            fc = FREQ_W'(1);
        end
        if (fc >= FREQ_W'(clk_eff)) begin
            fc = FREQ_W'(clk_eff) - FREQ_W'(1);
        end
        count_sat = (s_sample_count > CNT_MAX) ? CNT_MAX : s_sample_count;

        s0_next        = '0;
        s0_next.valid  = s_valid;
        s0_next.tw_rem = TWREM_W'(fc);
        s0_next.h_den  = DEN_W'(s_frequency_hz) * DEN_W'(count_sat);
        s0_next.count  = count_sat;
        s0_next.err    = (s_sample_count < COUNT_W'(2));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s0_reg.valid <= 1'b0;
        end else if (adv) begin
            s0_reg <= s0_next;
        end
    end

    assign chain[0] = s0_reg;

    for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
        localparam int MODE  = (k == 0) ? HMODE_INIT :
                               (k <= HQ_W) ? HMODE_STEP : HMODE_PASS;
        localparam int SHIFT = (k >= 1 && k <= HQ_W) ? HQ_W - k : 0;
        wtc_cell #(
            .HMODE  (MODE),
            .HSHIFT (SHIFT)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .clk_eff (clk_eff),
            .d_in    (chain[k]),
            .d_out   (chain[k+1])
        );
    end

    assign last = chain[N_CELLS];

    always_comb begin
        // zero divisor or zero quotient both give one, top bit means saturate
        if (last.h_den == '0) begin
            hold_next = HOLD_W'(1);
        end else if (last.h_q[HQ_W-1]) begin
            hold_next = HOLD_MAX;
        end else if (last.h_q[HOLD_W-1:0] == '0) begin
            hold_next = HOLD_W'(1);
        end else begin
            hold_next = last.h_q[HOLD_W-1:0];
        end
        prod        = (COUNT_W+HOLD_W)'(last.count) * (COUNT_W+HOLD_W)'(hold_next);
        period_next = (prod > (COUNT_W+HOLD_W)'(PERIOD_MAX)) ? PERIOD_MAX
                                                             : prod[PERIOD_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= last.valid;
            tw_reg      <= last.tw_q;
            err_reg     <= last.err;
            if (last.err) begin
                hold_reg   <= '0;
                period_reg <= '0;
                stop_reg   <= '0;
                tb_reg     <= '0;
            end else begin
                hold_reg   <= hold_next;
                period_reg <= period_next;
                stop_reg   <= STOP_W'(last.count - COUNT_W'(1));
                tb_reg     <= {hold_next, TIMEBASE_LOW};
            end
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_tuning_word    = tw_reg;
    assign m_sample_hold    = hold_reg;
    assign m_pattern_period = period_reg;
    assign m_stop_address   = stop_reg;
    assign m_timebase_word  = tb_reg;
    assign m_count_error    = err_reg;

    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_count_error) |-> (m_sample_hold == '0 && m_timebase_word == '0))
        else $error("timing fields not cleared on count error");
    a_hold_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_count_error) |-> (m_sample_hold != '0 && m_pattern_period != '0))
        else $error("hold or period zero on good count");

endmodule

// ===== rtl/wtc_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtc_cell
// One step of the tuning word division and, by mode, one step of the hold
// division, registered toward the next cell.
// ----------------------------------------------------------------------------
module wtc_cell import wtc_pkg::*; #(
    parameter int HMODE  = 0,
    parameter int HSHIFT = 0
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             en,
    input  logic [CLK_W-1:0] clk_eff,
    input  cell_data_t       d_in,
    output cell_data_t       d_out
);

    cell_data_t         data_reg;
    cell_data_t         data_next;
    logic [TWREM_W-1:0] tw_rem2;
    logic [CMP_W-1:0]   den_sh;
    logic [CMP_W-1:0]   rem_ext;

    always_comb begin
        data_next = d_in;
        tw_rem2   = {d_in.tw_rem[TWREM_W-2:0], 1'b0};
        if (tw_rem2 >= {1'b0, clk_eff}) begin
            data_next.tw_rem = tw_rem2 - {1'b0, clk_eff};
            data_next.tw_q   = {d_in.tw_q[TW_W-2:0], 1'b1};
        end else begin
            data_next.tw_rem = tw_rem2;
            data_next.tw_q   = {d_in.tw_q[TW_W-2:0], 1'b0};
        end

        den_sh  = CMP_W'(d_in.h_den) << HSHIFT;
        rem_ext = CMP_W'(d_in.h_rem);
        if (HMODE == HMODE_INIT) begin
            // rounding: add half the divisor up front
            data_next.h_rem = HREM_W'(clk_eff) + HREM_W'(d_in.h_den >> 1);
        end else if (HMODE == HMODE_STEP) begin
            if (rem_ext >= den_sh) begin
                data_next.h_rem = HREM_W'(rem_ext - den_sh);
                data_next.h_q   = {d_in.h_q[HQ_W-2:0], 1'b1};
            end else begin
                data_next.h_q   = {d_in.h_q[HQ_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg.valid <= 1'b0;
        end else if (en) begin
            data_reg <= data_next;
        end
    end

    assign d_out = data_reg;

endmodule
